// ----- rtl/pid_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_pkg
// Shared types and constants of the fixed-point PID controller with
// integral clamp: register indexes, opcodes, the register file view and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pid_pkg;

  // Fixed widths of the register file, the time step, the integral and the drive, and fraction bits.
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DT_W      = 16;
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = 32;
  localparam int DRIVE_W   = 16;
  localparam int GAIN_FRAC = 8;

  // Register indexes on the configuration channel.
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_HIGH = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LOW    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_HIGH   = 3'd6;

  // Reset values of the limit registers.
  localparam logic [CFG_W-1:0] RST_LIMIT_LOW  = 16'h8000;
  localparam logic [CFG_W-1:0] RST_LIMIT_HIGH = 16'h7fff;

  // Sample opcodes.
  localparam logic OP_SUPPLIED = 1'b0;
  localparam logic OP_COMPUTED = 1'b1;

  // Register file contents, all two's complement.
  typedef struct packed {
    logic [CFG_W-1:0] prop_gain;
    logic [CFG_W-1:0] integ_gain;
    logic [CFG_W-1:0] deriv_gain;
    logic [CFG_W-1:0] integ_low_limit;
    logic [CFG_W-1:0] integ_high_limit;
    logic [CFG_W-1:0] out_low_limit;
    logic [CFG_W-1:0] out_high_limit;
  } pid_cfg_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic saturate;
    logic mul;
    logic integ;
    logic sum;
    logic clamp;
    logic finish;
    logic zero_out;
  } pid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic computed;
    logic dt_zero;
  } pid_stat_t;

endpackage
`default_nettype wire

// ----- rtl/pid_channels.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_channels
// Valid/ready channel interfaces of the PID controller: control samples in,
// drive values out, and register writes.
// ----------------------------------------------------------------------------

// Control sample channel.
interface pid_in_if #(
  parameter int DATA_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic                         opcode;
  logic signed [DATA_WIDTH-1:0] err_sample;
  logic signed [DATA_WIDTH-1:0] deriv_sample;
  logic [15:0]                  time_step;

  modport source (output valid, opcode, err_sample, deriv_sample, time_step, input ready);
  modport sink   (input valid, opcode, err_sample, deriv_sample, time_step, output ready);
endinterface

// Drive result channel.
interface pid_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] drive;

  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface

// Register write channel.
interface pid_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

// ----- rtl/pid_controller_antiwindup.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_controller_antiwindup
// Fixed-point PID controller with integral clamp. Each control sample
// updates a Q16.16 integral and produces one saturated drive value.
//
//   Channel  Direction  Payload                                      Transfer
//   in_i     sink       opcode, err_sample, deriv_sample, time_step  valid & ready
//   out_o    source     drive                                        valid & ready
//   cfg_i    sink       index, wdata                                 valid & ready
//
// A supplied-derivative sample skips the divider; a computed-derivative
// sample runs the divider, which retires one quotient bit per cycle.
// A computed sample with zero time step skips the arithmetic and goes
// straight to a zero drive value.
// One sample is processed at a time; the next is taken once the result is
// in the output register, which holds it until transferred.
// Reset clears the integral, the last error and the gains at once, and sets the limits to the full range.
// ----------------------------------------------------------------------------
module pid_controller_antiwindup
  import pid_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  pid_in_if.sink    in_i,
  pid_out_if.source out_o,
  pid_cfg_if.sink   cfg_i
);

  pid_cfg_t  cfg;
  pid_cmd_t  cmd;
  pid_stat_t stat;

  // Gain and limit registers.
  pid_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Step sequencer.
  pid_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic and controller state.
  pid_datapath #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .opcode_i       (in_i.opcode),
    .err_sample_i   (in_i.err_sample),
    .deriv_sample_i (in_i.deriv_sample),
    .time_step_i    (in_i.time_step),
    .drive_o        (out_o.drive)
  );

  // A sample transfer always leaves the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input taken again right after a transfer");

  // A result is never written over one that has not been transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_o.valid || out_o.ready))
    else $error("unread result overwritten");

  // At most one step of the sequence is active in any cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.prep, cmd.div_step, cmd.saturate, cmd.mul,
              cmd.integ, cmd.sum, cmd.clamp, cmd.finish}))
    else $error("overlapping step commands");

  // A result appears only after a finish command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(cmd.finish))
    else $error("result valid without finish");

endmodule
`default_nettype wire

// ----- rtl/pid_cfg_regs.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_cfg_regs
// Register file of gains and limits, written over the configuration channel.
// Writes to an index beyond the last register are accepted and dropped.
// ----------------------------------------------------------------------------
module pid_cfg_regs
  import pid_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  pid_cfg_if.sink    cfg_i,
  output pid_cfg_t   cfg_o
);

  pid_cfg_t regs_q;

  // The register file can always take a write.
  assign cfg_i.ready = 1'b1;
  assign cfg_o       = regs_q;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q.prop_gain        <= '0;
      regs_q.integ_gain       <= '0;
      regs_q.deriv_gain       <= '0;
      regs_q.integ_low_limit  <= RST_LIMIT_LOW;
      regs_q.integ_high_limit <= RST_LIMIT_HIGH;
      regs_q.out_low_limit    <= RST_LIMIT_LOW;
      regs_q.out_high_limit   <= RST_LIMIT_HIGH;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_PROP_GAIN:  regs_q.prop_gain        <= cfg_i.wdata;
        REG_INTEG_GAIN: regs_q.integ_gain       <= cfg_i.wdata;
        REG_DERIV_GAIN: regs_q.deriv_gain       <= cfg_i.wdata;
        REG_INTEG_LOW:  regs_q.integ_low_limit  <= cfg_i.wdata;
        REG_INTEG_HIGH: regs_q.integ_high_limit <= cfg_i.wdata;
        REG_OUT_LOW:    regs_q.out_low_limit    <= cfg_i.wdata;
        REG_OUT_HIGH:   regs_q.out_high_limit   <= cfg_i.wdata;
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pid_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_ctrl
// Sequencer of the PID step: prepares operands, runs the derivative divider
// one quotient bit per cycle for a computed derivative, then multiplies,
// integrates, sums, clamps and hands the result to the output register.
// ----------------------------------------------------------------------------
module pid_ctrl
  import pid_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire pid_stat_t  stat_i,
  output pid_cmd_t        cmd_o
);

  localparam int QW = DATA_WIDTH + 1;
  localparam int CW = $clog2(QW);
  localparam logic [CW-1:0] CNT_LAST = CW'(QW - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_DIV, S_SAT, S_MUL, S_INTEG, S_SUM, S_CLAMP, S_FIN, S_ZERO
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q;
  logic          out_valid_q;
  logic          out_free;

  // The result register is free when empty or being read this cycle.
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Command decode.
  always_comb begin
    cmd_o          = '0;
    cmd_o.load     = (state_q == S_IDLE) && in_valid_i;
    cmd_o.prep     = (state_q == S_PREP);
    cmd_o.div_step = (state_q == S_DIV);
    cmd_o.saturate = (state_q == S_SAT);
    cmd_o.mul      = (state_q == S_MUL);
    cmd_o.integ    = (state_q == S_INTEG);
    cmd_o.sum      = (state_q == S_SUM);
    cmd_o.clamp    = (state_q == S_CLAMP);
    cmd_o.finish   = ((state_q == S_FIN) || (state_q == S_ZERO)) && out_free;
    cmd_o.zero_out = (state_q == S_ZERO);
  end

  // State, divider step count and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          cnt_q <= '0;
          if (stat_i.computed && stat_i.dt_zero) begin
            state_q <= S_ZERO;
          end else if (stat_i.computed) begin
            state_q <= S_DIV;
          end else begin
            state_q <= S_MUL;
          end
        end
        S_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= S_SAT;
          end
        end
        S_SAT:   state_q <= S_MUL;
        S_MUL:   state_q <= S_INTEG;
        S_INTEG: state_q <= S_SUM;
        S_SUM:   state_q <= S_CLAMP;
        S_CLAMP: state_q <= S_FIN;
        S_FIN, S_ZERO: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/pid_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// pid_datapath
// Operand registers, restoring divider for the computed derivative, gain
// multipliers, integral update with clamp, output sum, clamp and rounding,
// and the controller state (integral and last error).
// ----------------------------------------------------------------------------
module pid_datapath
  import pid_pkg::*;
#(
  parameter int DATA_WIDTH = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire pid_cfg_t                     cfg_i,
  input  wire pid_cmd_t                     cmd_i,
  output pid_stat_t                         stat_o,
  input  wire logic                         opcode_i,
  input  wire logic signed [DATA_WIDTH-1:0] err_sample_i,
  input  wire logic signed [DATA_WIDTH-1:0] deriv_sample_i,
  input  wire logic [DT_W-1:0]              time_step_i,
  output logic signed [DRIVE_W-1:0]         drive_o
);

  localparam int DW = DATA_WIDTH;
  localparam int QW = DW + 1;                 // quotient bits kept
  localparam int NW = QW + FRAC_W;            // dividend width
  localparam int PW = DW + CFG_W;             // gain product width
  localparam int IW = PW + DT_W + 1;          // integral increment product
  localparam int AW = IW - GAIN_FRAC + 1;     // wide sum width
  localparam logic [QW-1:0] Q_HALF = QW'(1) << (DW - 1);
  localparam logic signed [ACC_W:0] ROUND_HALF = (ACC_W + 1)'(1) << (FRAC_W - 1);

  // Sample and state registers.
  logic                   op_q;
  logic signed [DW-1:0]   e_q;
  logic signed [DW-1:0]   d_q;
  logic [DT_W-1:0]        dt_q;
  logic signed [DW-1:0]   prev_err_q;
  logic signed [ACC_W-1:0] integ_acc_q;

  // Divider registers.
  logic                   neg_q;
  logic                   ovf_q;
  logic [DT_W-1:0]        rem_q;
  logic [QW-1:0]          quo_q;

  // Arithmetic pipeline registers.
  logic signed [PW-1:0]   prod_p_q;
  logic signed [PW-1:0]   prod_i_q;
  logic signed [PW-1:0]   prod_d_q;
  logic signed [IW-1:0]   inc_q;
  logic signed [PW:0]     pd_sum_q;
  logic signed [ACC_W-1:0] acc_new_q;
  logic signed [AW-1:0]   sum_q;
  logic signed [DRIVE_W-1:0] drive_res_q;
  logic signed [DRIVE_W-1:0] drive_q;

  assign stat_o.computed = (op_q == OP_COMPUTED);
  assign stat_o.dt_zero  = (dt_q == '0);
  assign drive_o         = drive_q;

  // Error difference, its magnitude and the dividend.
  logic signed [DW:0] diff;
  logic [DW:0]        mag;
  logic [NW-1:0]      num;
  logic [NW-1:0]      dt_top;
  logic               ovf_d;

  assign diff   = {e_q[DW-1], e_q} - {prev_err_q[DW-1], prev_err_q};
  assign mag    = diff[DW] ? (~diff + 1'b1) : diff;
  assign num    = {mag, {FRAC_W{1'b0}}};
  assign dt_top = {dt_q, {QW{1'b0}}};
  assign ovf_d  = (num >= dt_top);

  // One restoring division step.
  logic [DT_W:0]   trial;
  logic [DT_W:0]   trial_sub;
  logic            q_bit;
  logic [DT_W-1:0] rem_d;

  assign trial     = {rem_q, quo_q[QW-1]};
  assign q_bit     = (trial >= {1'b0, dt_q});
  assign trial_sub = trial - {1'b0, dt_q};
  assign rem_d     = q_bit ? trial_sub[DT_W-1:0] : trial[DT_W-1:0];

  // Saturation of the quotient to the signed sample range.
  logic [QW-1:0]        quo_neg;
  logic signed [DW-1:0] d_sat;

  assign quo_neg = QW'(0) - quo_q;
  always_comb begin
    if (neg_q) begin
      if (ovf_q || (quo_q > Q_HALF)) begin
        d_sat = {1'b1, {(DW - 1){1'b0}}};
      end else begin
        d_sat = quo_neg[DW-1:0];
      end
    end else begin
      if (ovf_q || (quo_q >= Q_HALF)) begin
        d_sat = {1'b0, {(DW - 1){1'b1}}};
      end else begin
        d_sat = quo_q[DW-1:0];
      end
    end
  end

  // Gain products.
  logic signed [PW-1:0] prod_p_d;
  logic signed [PW-1:0] prod_i_d;
  logic signed [PW-1:0] prod_d_d;
  logic signed [IW-1:0] inc_d;

  assign prod_p_d = $signed(cfg_i.prop_gain) * e_q;
  assign prod_i_d = $signed(cfg_i.integ_gain) * e_q;
  assign prod_d_d = $signed(cfg_i.deriv_gain) * d_q;
  assign inc_d    = prod_i_q * $signed({1'b0, dt_q});

  // Integral update, floored to Q16.16, clamped low then high.
  logic signed [IW-GAIN_FRAC-1:0] inc_fl;
  logic signed [AW-1:0]    acc_sum;
  logic signed [AW-1:0]    acc_lo;
  logic signed [AW-1:0]    acc_cl;
  logic signed [ACC_W-1:0] ilo;
  logic signed [ACC_W-1:0] ihi;

  assign inc_fl  = inc_q[IW-1:GAIN_FRAC];
  assign ilo     = {cfg_i.integ_low_limit, {FRAC_W{1'b0}}};
  assign ihi     = {cfg_i.integ_high_limit, {FRAC_W{1'b0}}};
  assign acc_sum = integ_acc_q + inc_fl;
  assign acc_lo  = (acc_sum < ilo) ? AW'(ilo) : acc_sum;
  assign acc_cl  = (acc_lo > ihi) ? AW'(ihi) : acc_lo;

  // Output sum, clamp and round to nearest.
  logic signed [PW+GAIN_FRAC:0] pd_scaled;
  logic signed [AW-1:0]    sum_d;
  logic signed [AW-1:0]    sum_lo;
  logic signed [AW-1:0]    sum_cl;
  logic signed [ACC_W-1:0] olo;
  logic signed [ACC_W-1:0] ohi;
  logic signed [ACC_W-1:0] sum_nar;
  logic signed [ACC_W:0]   rnd;

  assign pd_scaled = {pd_sum_q, {GAIN_FRAC{1'b0}}};
  assign sum_d     = pd_scaled + acc_new_q;
  assign olo       = {cfg_i.out_low_limit, {FRAC_W{1'b0}}};
  assign ohi       = {cfg_i.out_high_limit, {FRAC_W{1'b0}}};
  assign sum_lo    = (sum_q < olo) ? AW'(olo) : sum_q;
  assign sum_cl    = (sum_lo > ohi) ? AW'(ohi) : sum_lo;
  assign sum_nar   = sum_cl[ACC_W-1:0];
  assign rnd       = {sum_nar[ACC_W-1], sum_nar} + ROUND_HALF;

  // Operand and pipeline registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= opcode_i;
      e_q  <= err_sample_i;
      d_q  <= deriv_sample_i;
      dt_q <= time_step_i;
    end
    if (cmd_i.prep) begin
      neg_q    <= diff[DW];
      ovf_q    <= ovf_d;
      rem_q    <= num[NW-1:QW];
      quo_q    <= num[QW-1:0];
      prod_p_q <= prod_p_d;
      prod_i_q <= prod_i_d;
    end
    if (cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[QW-2:0], q_bit};
    end
    if (cmd_i.saturate) begin
      d_q <= d_sat;
    end
    if (cmd_i.mul) begin
      inc_q    <= inc_d;
      prod_d_q <= prod_d_d;
    end
    if (cmd_i.integ) begin
      acc_new_q <= acc_cl[ACC_W-1:0];
      pd_sum_q  <= prod_p_q + prod_d_q;
    end
    if (cmd_i.sum) begin
      sum_q <= sum_d;
    end
    if (cmd_i.clamp) begin
      drive_res_q <= rnd[ACC_W-1:FRAC_W];
    end
    if (cmd_i.finish) begin
      drive_q <= cmd_i.zero_out ? '0 : drive_res_q;
    end
  end

  // Controller state: commits only on a completed step with a real result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_acc_q <= '0;
      prev_err_q  <= '0;
    end else if (cmd_i.finish && !cmd_i.zero_out) begin
      integ_acc_q <= acc_new_q;
      prev_err_q  <= e_q;
    end
  end

endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench of the fixed-point PID controller with integral
// clamp. Control samples wait in a pending queue and go to the block through
// a clocked driver. Every accepted sample is run through a local fixed-point
// model of the controller, and the drive values that leave the block are
// checked in order against the model. Register settings change only between
// phases, while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;
  import pid_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 500_000;
  localparam int          NUM_REGS      = 7;
  localparam int          RANDOM_SETS   = 6;
  localparam int          ITEMS_PER_SET = 150;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          SETTLE_CYCLES = 30;

  // Index past the last register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  typedef struct {
    logic               opcode;
    logic signed [15:0] err_sample;
    logic signed [15:0] deriv_sample;
    logic [DT_W-1:0]    time_step;
  } pid_sample_t;

  typedef logic [CFG_W-1:0] reg_set_t [NUM_REGS];

  logic clk;
  logic rst_n;

  pid_in_if #(.DATA_WIDTH(16)) in_ch ();
  pid_out_if                   out_ch ();
  pid_cfg_if                   cfg_ch ();

  pid_controller_antiwindup #(
    .DATA_WIDTH(16)
  ) dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch),
    .cfg_i (cfg_ch)
  );

  // Shadow registers and controller state of the model.
  longint reg_model [NUM_REGS];
  longint integ_model;
  longint last_err_model;

  pid_sample_t        pending_samples [$];
  logic signed [15:0] expected_drives [$];
  pid_sample_t        taken;
  logic signed [15:0] drive_want;

  int          send_idle_pct;
  int          recv_idle_pct;
  int          holds_wanted;
  int          holds_served;
  int          hold_left;
  bit          in_taken;
  int          error_count;
  int          samples_taken;
  int          computed_taken;
  int          zero_dt_taken;
  int          drives_checked;
  int          settings_loaded;
  int unsigned cycle_count;

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Fixed-point controller step: updates the model state and returns the
  // drive value that the block must produce for this sample.
  function automatic logic signed [DRIVE_W-1:0] predict_drive(input pid_sample_t s);
    longint e;
    longint d;
    longint dt;
    longint diff;
    longint mag;
    longint acc;
    longint sum;
    e  = s.err_sample;
    d  = s.deriv_sample;
    dt = s.time_step;
    if (s.opcode == OP_COMPUTED) begin
      // A zero time step forces the drive to zero and leaves the state alone.
      if (dt == 0) return '0;
      diff = e - last_err_model;
      mag  = (((diff < 0) ? -diff : diff) <<< FRAC_W) / dt;
      if (diff < 0) d = (mag > 32768) ? -32768 : -mag;
      else d = (mag > 32767) ? 32767 : mag;
    end
    // Integral update, floored to Q16.16, then the low clamp before the high.
    acc = integ_model + ((reg_model[REG_INTEG_GAIN] * e * dt) >>> GAIN_FRAC);
    if (acc < (reg_model[REG_INTEG_LOW] <<< FRAC_W)) acc = reg_model[REG_INTEG_LOW] <<< FRAC_W;
    if (acc > (reg_model[REG_INTEG_HIGH] <<< FRAC_W)) acc = reg_model[REG_INTEG_HIGH] <<< FRAC_W;
    integ_model = acc;
    // Output sum in Q16.16, clamped, then rounded with halves going up.
    sum = ((reg_model[REG_PROP_GAIN] * e) <<< GAIN_FRAC) + acc
        + ((reg_model[REG_DERIV_GAIN] * d) <<< GAIN_FRAC);
    if (sum < (reg_model[REG_OUT_LOW] <<< FRAC_W)) sum = reg_model[REG_OUT_LOW] <<< FRAC_W;
    if (sum > (reg_model[REG_OUT_HIGH] <<< FRAC_W)) sum = reg_model[REG_OUT_HIGH] <<< FRAC_W;
    last_err_model = e;
    return DRIVE_W'((sum + (1 << (FRAC_W - 1))) >>> FRAC_W);
  endfunction

  function automatic void queue_sample(input logic op, input logic [15:0] e,
                                       input logic [15:0] d, input logic [DT_W-1:0] dt);
    pid_sample_t s;
    s.opcode       = op;
    s.err_sample   = e;
    s.deriv_sample = d;
    s.time_step    = dt;
    pending_samples.push_back(s);
  endfunction

  function automatic logic [CFG_W-1:0] random_gain();
    case ($urandom_range(0, 7))
      0:       return 16'h7fff;
      1:       return 16'h8000;
      2:       return '0;
      3, 4:    return 16'($urandom_range(0, 512) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Picks a limit pair: full range, narrow around zero, ordinary, or reversed.
  function automatic void pick_limits(output logic [CFG_W-1:0] lo, output logic [CFG_W-1:0] hi);
    logic signed [CFG_W-1:0] a;
    logic signed [CFG_W-1:0] b;
    int                      sel;
    a   = 16'($urandom);
    b   = 16'($urandom);
    sel = $urandom_range(0, 7);
    if (sel == 0) begin
      lo = RST_LIMIT_LOW;
      hi = RST_LIMIT_HIGH;
    end else begin
      if (sel < 3) begin
        a = a >>> 6;
        b = b >>> 6;
      end
      // Selection 3 puts the larger value in the low limit.
      if ((sel == 3) == (a < b)) begin
        lo = b;
        hi = a;
      end else begin
        lo = a;
        hi = b;
      end
    end
  endfunction

  function automatic reg_set_t random_settings();
    reg_set_t v;
    v[REG_PROP_GAIN]  = random_gain();
    v[REG_INTEG_GAIN] = random_gain();
    v[REG_DERIV_GAIN] = random_gain();
    pick_limits(v[REG_INTEG_LOW], v[REG_INTEG_HIGH]);
    pick_limits(v[REG_OUT_LOW], v[REG_OUT_HIGH]);
    return v;
  endfunction

  function automatic pid_sample_t random_sample();
    pid_sample_t s;
    s.opcode = $urandom_range(0, 1) ? OP_COMPUTED : OP_SUPPLIED;
    case ($urandom_range(0, 3))
      0:       s.err_sample = 16'($urandom);
      1:       s.err_sample = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: s.err_sample = 16'($urandom_range(0, 4000) - 2000);
    endcase
    s.deriv_sample = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 2000) - 1000);
    case ($urandom_range(0, 9))
      0:       s.time_step = '0;
      1:       s.time_step = '1;
      2, 3:    s.time_step = 16'($urandom);
      default: s.time_step = 16'($urandom_range(1, 3000));
    endcase
    return s;
  endfunction

  // One register write; the valid stays up for a following write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.wdata <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx < NUM_REGS) reg_model[idx] = longint'($signed(val));
  endtask

  task automatic load_settings(input reg_set_t vals);
    for (int i = 0; i < NUM_REGS; i++) write_reg(CFG_IDX_W'(i), vals[i]);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    settings_loaded++;
  endtask

  // Waits until every queued sample is taken and every drive value checked.
  task automatic wait_idle();
    while (pending_samples.size() != 0 || expected_drives.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sample driver: presents the oldest pending sample, with random gaps.
  always @(negedge clk) begin
    if (!in_ch.valid || in_taken) begin
      if (pending_samples.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid        <= 1'b1;
        in_ch.opcode       <= pending_samples[0].opcode;
        in_ch.err_sample   <= pending_samples[0].err_sample;
        in_ch.deriv_sample <= pending_samples[0].deriv_sample;
        in_ch.time_step    <= pending_samples[0].time_step;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Drive receiver: random stalls, plus long hold-offs on request.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (holds_served < holds_wanted) begin
      hold_left = HOLD_CYCLES;
      holds_served++;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Sample transfers: predict the drive value of each accepted sample.
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      in_taken = 1'b1;
      void'(pending_samples.pop_front());
      taken.opcode       = in_ch.opcode;
      taken.err_sample   = in_ch.err_sample;
      taken.deriv_sample = in_ch.deriv_sample;
      taken.time_step    = in_ch.time_step;
      expected_drives.push_back(predict_drive(taken));
      samples_taken++;
      if (taken.opcode == OP_COMPUTED) computed_taken++;
      if (taken.time_step == '0) zero_dt_taken++;
    end
  end

  // Drive transfers: compare against the oldest expected value.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_drives.size() == 0) begin
        error_count++;
        $display("%0t ERROR unexpected drive: expected none actual %0d", $time, out_ch.drive);
      end else begin
        drive_want = expected_drives.pop_front();
        drives_checked++;
        if (out_ch.drive !== drive_want) begin
          error_count++;
          $display("%0t ERROR drive mismatch: expected %0d actual %0d",
                   $time, drive_want, out_ch.drive);
        end
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t ERROR timeout after %0d cycles, %0d drive values outstanding",
             $time, cycle_count, expected_drives.size());
    $display("*** FAILED ***");
    $finish;
  end

  // Stimulus sequence.
  initial begin : stimulus
    reg_set_t settings;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = OP_SUPPLIED;
    in_ch.err_sample   = '0;
    in_ch.deriv_sample = '0;
    in_ch.time_step    = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = REG_PROP_GAIN;
    cfg_ch.wdata       = '0;
    send_idle_pct      = 35;
    recv_idle_pct      = 59;
    holds_wanted       = 0;
    holds_served       = 0;
    hold_left          = 0;
    in_taken           = 1'b0;
    error_count        = 0;
    samples_taken      = 0;
    computed_taken     = 0;
    zero_dt_taken      = 0;
    drives_checked     = 0;
    settings_loaded    = 0;
    reg_model[REG_PROP_GAIN]  = 0;
    reg_model[REG_INTEG_GAIN] = 0;
    reg_model[REG_DERIV_GAIN] = 0;
    reg_model[REG_INTEG_LOW]  = -32768;
    reg_model[REG_INTEG_HIGH] = 32767;
    reg_model[REG_OUT_LOW]    = -32768;
    reg_model[REG_OUT_HIGH]   = 32767;
    integ_model    = 0;
    last_err_model = 0;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Field extremes, derivative saturation both ways and zero time steps.
    settings = '{16'h0100, 16'h7fff, 16'h8000, 16'hff9c, 16'h0064, 16'h8000, 16'h7fff};
    load_settings(settings);
    @(posedge clk);
    queue_sample(OP_SUPPLIED, 16'h7fff, 16'h8000, 16'hffff);
    queue_sample(OP_SUPPLIED, 16'h8000, 16'h7fff, 16'hffff);
    queue_sample(OP_COMPUTED, 16'h7fff, 16'h0000, 16'h0001);
    queue_sample(OP_COMPUTED, 16'h8000, 16'h0000, 16'h0001);
    queue_sample(OP_COMPUTED, 16'h0000, 16'h1234, 16'h0000);
    queue_sample(OP_SUPPLIED, 16'h0005, 16'h0000, 16'h0000);
    queue_sample(OP_COMPUTED, 16'h0064, 16'h0000, 16'hffff);
    queue_sample(OP_COMPUTED, 16'h0000, 16'h0000, 16'h0003);
    queue_sample(OP_SUPPLIED, 16'h0000, 16'h0000, 16'h0000);
    queue_sample(OP_COMPUTED, 16'hffff, 16'h0000, 16'h0002);
    wait_idle();

    // Reversed limits on both clamps, extreme gains, write past the last register.
    write_reg(REG_SPARE, 16'h1234);
    settings = '{16'h7fff, 16'h8000, 16'h7fff, 16'h0032, 16'hffce, 16'h03e8, 16'hfc18};
    load_settings(settings);
    @(posedge clk);
    queue_sample(OP_SUPPLIED, 16'h0100, 16'h0100, 16'h8000);
    queue_sample(OP_COMPUTED, 16'hff00, 16'h0000, 16'h0010);
    queue_sample(OP_SUPPLIED, 16'h8000, 16'h8000, 16'hffff);
    queue_sample(OP_COMPUTED, 16'h7fff, 16'h0000, 16'hffff);
    queue_sample(OP_SUPPLIED, 16'h0000, 16'h0000, 16'h0000);
    queue_sample(OP_COMPUTED, 16'h0000, 16'h0000, 16'h0000);
    wait_idle();

    // Rounding of half values and narrow output limits.
    settings = '{16'h0080, 16'h0001, 16'hff80, 16'h8000, 16'h7fff, 16'hfffb, 16'h0005};
    load_settings(settings);
    @(posedge clk);
    queue_sample(OP_SUPPLIED, 16'h0001, 16'h0000, 16'h0000);
    queue_sample(OP_SUPPLIED, 16'hffff, 16'h0000, 16'h0000);
    queue_sample(OP_SUPPLIED, 16'h0003, 16'h0001, 16'h0000);
    queue_sample(OP_SUPPLIED, 16'hfffd, 16'h0000, 16'h0000);
    queue_sample(OP_SUPPLIED, 16'h0100, 16'h0000, 16'h0000);
    queue_sample(OP_SUPPLIED, 16'hff00, 16'h0000, 16'h0000);
    queue_sample(OP_COMPUTED, 16'h0002, 16'h0000, 16'h8000);
    queue_sample(OP_COMPUTED, 16'h0002, 16'h0000, 16'hffff);
    wait_idle();

    // Random phases, each with its own register setting; the idle pattern changes every two phases.
    for (int k = 0; k < RANDOM_SETS; k++) begin
      if (k < 2) begin
        send_idle_pct = 35;
        recv_idle_pct = 59;
      end else if (k < 4) begin
        send_idle_pct = 59;
        recv_idle_pct = 35;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      load_settings(random_settings());
      @(posedge clk);
      for (int n = 0; n < ITEMS_PER_SET; n++) pending_samples.push_back(random_sample());
      // Back up the block while samples keep coming.
      if (k == 4) holds_wanted++;
      wait_idle();
    end

    $display("Run covered %0d samples (%0d computed derivative, %0d zero time step)",
             samples_taken, computed_taken, zero_dt_taken);
    $display("under %0d register settings; %0d drive values checked, %0d errors.",
             settings_loaded, drives_checked, error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
